// ===== design/itd_pkg.sv =====
// ----------------------------------------------------------------------------
// itd_pkg: shared definitions for the radix digit converter
// Field widths, ASCII constants, radix clamping, digit encoding and the
// status bundle returned by the shared divider.
// ----------------------------------------------------------------------------
package itd_pkg;

  localparam int VALUE_W  = 64;
  localparam int RADIX_W  = 6;
  localparam int CHAR_W   = 7;
  localparam int COUNT_W  = 7;
  localparam int STEP_W   = 6;   // counts the VALUE_W quotient bits of one division
  localparam int S_DATA_W = 72;  // value + radix, padded to whole bytes
  localparam int M_DATA_W = 16;  // digit_char + digit_count, padded to whole bytes

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_BASE   = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;

  // Status of the shared divider, valid in the cycle that done is high.
  typedef struct packed {
    logic done;
    logic quo_zero;
  } itd_div_stat_t;

  // Bases below two act as two; bases above thirty-six act as thirty-six.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d >= DEC_BASE) begin
      res = ASCII_A + CHAR_W'(d - DEC_BASE);
    end else begin
      res = ASCII_ZERO + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage

// ===== design/itd_div.sv =====
// ----------------------------------------------------------------------------
// itd_div: bit-serial restoring divider
// Divides a 64-bit dividend by a 6-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [itd_pkg::VALUE_W-1:0]  dividend,
  input  logic [itd_pkg::RADIX_W-1:0]  divisor,
  output logic [itd_pkg::VALUE_W-1:0]  quotient,
  output logic [itd_pkg::RADIX_W-1:0]  remainder,
  output itd_pkg::itd_div_stat_t       stat
);
  import itd_pkg::*;

  logic [VALUE_W-1:0] quo;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] dvs;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;

  logic [RADIX_W:0]   trial;
  logic [RADIX_W:0]   diff;
  logic               fits;
  logic [RADIX_W-1:0] rem_next;

  // The partial remainder stays below the divisor, so trial is below twice it.
  always_comb begin
    trial    = {rem, quo[VALUE_W-1]};
    diff     = trial - {1'b0, dvs};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == STEP_W'(VALUE_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[VALUE_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient      = quo;
  assign remainder     = rem;
  assign stat.done     = done;
  assign stat.quo_zero = (quo == '0);

endmodule

// ===== design/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits: unsigned integer to ASCII digits in a chosen base
// Converts a 64-bit value to its digits in base 2..36, most significant first.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents
//  -------  ---  ---------------------------------------------------------
//  s_*      in   one number: value and radix
//  m_*      out  one ASCII digit; tlast on the least significant digit,
//                which also carries the digit count
//
// Each digit costs one pass of the bit-serial divider, after which the
// remainder is stored on the stack; each output beat is a stack read
// (ST_RD) followed by the beat itself (ST_OUT). Reset (rst, synchronous)
// returns the sequencer to idle and drops any item in progress. A stall on
// m_tready holds the current beat; s_tready is low from acceptance until
// the final beat has been taken.
module integer_to_radix_digits #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, from bit 0: value[63:0], radix[69:64], zero padding[71:70]
  input  logic [itd_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, from bit 0: digit_char[6:0], digit_count[13:7], zero padding[15:14]
  output logic [itd_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);
  import itd_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   ptr;
  logic [RADIX_W-1:0] radix;
  logic [CHAR_W-1:0]  rd_char;

  // The digit stack: written least significant digit first, read back in
  // reverse order.
  logic [CHAR_W-1:0]  stack [MAX_DIGITS];

  logic               accept;
  logic               div_start;
  logic               more;
  logic [VALUE_W-1:0] div_dividend;
  logic [RADIX_W-1:0] div_divisor;
  logic [VALUE_W-1:0] div_quo;
  logic [RADIX_W-1:0] div_rem;
  itd_div_stat_t      div_stat;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Another division follows while the quotient is nonzero and the stack has
  // room. Zero goes through the loop once and yields the single digit '0'.
  assign more      = !div_stat.quo_zero && (count != CNT_W'(MAX_DIGITS - 1));
  assign div_start = accept || ((state == ST_DIV) && div_stat.done && more);

  assign div_dividend = accept ? s_tdata[VALUE_W-1:0] : div_quo;
  assign div_divisor  = accept ? clamp_radix(s_tdata[VALUE_W +: RADIX_W]) : radix;

  itd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ptr   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            count <= count + 1'b1;
            if (!more) begin
              ptr   <= count[IDX_W-1:0];
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            if (ptr == '0) begin
              state <= ST_IDLE;
            end else begin
              ptr   <= ptr - 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      radix <= clamp_radix(s_tdata[VALUE_W +: RADIX_W]);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DIV) && div_stat.done) begin
      stack[count[IDX_W-1:0]] <= digit_to_ascii(div_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      rd_char <= stack[ptr];
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tlast  = (ptr == '0);
  assign m_tdata  = {{(M_DATA_W - CHAR_W - COUNT_W){1'b0}},
                     (m_tlast ? COUNT_W'(count) : COUNT_W'(0)),
                     rd_char};

  // The beat being shown always comes from a filled stack entry.
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CNT_W'(ptr) < count))
    else $error("output pointer beyond the filled part of the stack");

  // Input and output are never open together: one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while digits are still being sent");

  // The final beat reports a count between one and the stack depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> ((count != '0) && (count <= CNT_W'(MAX_DIGITS))))
    else $error("digit count out of range on the final beat");

  // A division result only arrives while the sequencer is dividing.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the division phase");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for integer_to_radix_digits
// Drives numbers and bases into the slave stream, predicts the ASCII digits of
// each accepted beat and checks every digit beat on the master stream in
// order, with random gaps on both sides and one long hold-off on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import itd_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int DIGITS_MAX    = 64;
  localparam int RANDOM_ITEMS  = 118;
  // A 64-digit item in base two spends one divider pass per digit before its
  // first beat, and the long hold-off comes on top of that. The
  // watchdog limit is several times the sum of the two.
  localparam int PRESS_CYCLES  = 3000;
  localparam int PRESS_AFTER   = 40;
  localparam int QUIET_LIMIT   = 30000;
  localparam int DRAIN_CYCLES  = 300;

  // One number to convert, as it travels on the slave stream.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } number_t;

  // One expected digit beat on the master stream.
  typedef struct {
    logic [CHAR_W-1:0]  digit_char;
    logic               is_last;
    logic [COUNT_W-1:0] digit_count;
  } digit_beat_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // s_tdata, from bit 0: value[63:0], radix[69:64], zero padding[71:70]
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // m_tdata, from bit 0: digit_char[6:0], digit_count[13:7], zero padding[15:14]
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  number_t     number_q[$];        // numbers still to be offered
  digit_beat_t expected_digits[$]; // digits predicted but not yet seen
  int          n_items     = 0;
  int          in_accepted = 0;
  int          beats_seen  = 0;
  int          errors      = 0;
  int          quiet       = 0;
  int          send_gap    = 0;
  int          ready_wait  = 0;
  int          press_cnt   = 0;
  bit          press_done  = 1'b0;
  logic        stall_hold  = 1'b0;
  logic        s_taken     = 1'b0;

  integer_to_radix_digits #(
    .MAX_DIGITS(DIGITS_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // Works out the digit beats that one accepted number must produce and
  // appends them to the expected queue, most significant digit first. The
  // base is clamped into the range two to thirty-six first, and a value of
  // zero gives a single '0' with a count of one. Should a value ever need
  // more digits than the stack holds, only the low digits are kept.
  function automatic void convert_to_digits(input logic [VALUE_W-1:0] value,
                                            input logic [RADIX_W-1:0] radix_in);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] rem_d;
    logic [CHAR_W-1:0]  stack [DIGITS_MAX];
    int                 n;
    digit_beat_t        beat;
    if (radix_in < RADIX_MIN) begin
      base = VALUE_W'(RADIX_MIN);
    end else if (radix_in > RADIX_MAX) begin
      base = VALUE_W'(RADIX_MAX);
    end else begin
      base = VALUE_W'(radix_in);
    end
    rest = value;
    n    = 0;
    if (rest == '0) begin
      stack[0] = ASCII_ZERO;
      n        = 1;
    end else begin
      while (rest != '0 && n < DIGITS_MAX) begin
        rem_d = rest % base;
        if (rem_d >= VALUE_W'(DEC_BASE)) begin
          stack[n] = ASCII_A + CHAR_W'(rem_d - VALUE_W'(DEC_BASE));
        end else begin
          stack[n] = ASCII_ZERO + CHAR_W'(rem_d);
        end
        rest = rest / base;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      beat.digit_char  = stack[n - 1 - k];
      beat.is_last     = (k == n - 1);
      beat.digit_count = beat.is_last ? COUNT_W'(n) : '0;
      expected_digits.push_back(beat);
    end
  endfunction

  function automatic void add_number(input logic [VALUE_W-1:0] value,
                                     input logic [RADIX_W-1:0] radix);
    number_t item;
    item.value = value;
    item.radix = radix;
    number_q.push_back(item);
  endfunction

  // Gap lengths for both sides: mostly none, often a few cycles, now and then
  // a long one. Runs of zero gaps give stretches at full rate.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Random values mostly use few bits so that most items stay short; one in
  // ten uses the full width.
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int                 sel;
    int                 w;
    v   = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      w = $urandom_range(0, 20);
    end else if (sel < 9) begin
      w = $urandom_range(21, 63);
    end else begin
      w = VALUE_W;
    end
    if (w < VALUE_W) begin
      v = v & ((64'd1 << w) - 64'd1);
    end
    return v;
  endfunction

  // Bases are mostly legal; the rest cover the whole six-bit field, so the
  // bases that get clamped turn up as well.
  function automatic logic [RADIX_W-1:0] rand_radix();
    if ($urandom_range(0, 9) < 8) begin
      return RADIX_W'($urandom_range(2, 36));
    end
    return RADIX_W'($urandom_range(0, 63));
  endfunction

  // Sender: a new beat is put up at the falling edge once the previous one
  // has gone, after a random gap. The valid line stays high between
  // back-to-back beats.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_taken)) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap--;
      end else if (number_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, number_q[0].radix, number_q[0].value};
        void'(number_q.pop_front());
        send_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready drops for random stretches, and for the whole of the
  // long hold-off below.
  always @(negedge clk) begin
    if (rst || stall_hold) begin
      m_tready <= 1'b0;
    end else if (ready_wait > 0) begin
      m_tready <= 1'b0;
      ready_wait--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        ready_wait = pick_gap();
      end
    end
  end

  // Long hold-off, once: after some beats have come the receiver refuses
  // everything for PRESS_CYCLES cycles while the sender keeps offering, so
  // the block has to stall its input.
  always @(negedge clk) begin
    if (!press_done && beats_seen >= PRESS_AFTER) begin
      if (press_cnt < PRESS_CYCLES) begin
        stall_hold <= 1'b1;
        press_cnt++;
      end else begin
        stall_hold <= 1'b0;
        press_done = 1'b1;
      end
    end
  end

  // Monitor: both handshakes are sampled at the rising edge. An accepted
  // input beat is predicted from what actually stood on the bus; an accepted
  // output beat is checked against the oldest prediction.
  always @(posedge clk) begin
    digit_beat_t want;
    s_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        convert_to_digits(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W+RADIX_W-1:VALUE_W]);
        in_accepted++;
      end
      if (m_tvalid && m_tready) begin
        beats_seen++;
        if (expected_digits.size() == 0) begin
          errors++;
          $display("%0t: unexpected digit beat: expected none, got char %h last %b count %0d",
                   $time, m_tdata[CHAR_W-1:0], m_tlast, m_tdata[CHAR_W+COUNT_W-1:CHAR_W]);
        end else begin
          want = expected_digits.pop_front();
          if (m_tdata[CHAR_W-1:0] !== want.digit_char) begin
            errors++;
            $display("%0t: digit_char mismatch: expected %h, got %h",
                     $time, want.digit_char, m_tdata[CHAR_W-1:0]);
          end
          if (m_tlast !== want.is_last) begin
            errors++;
            $display("%0t: is_last mismatch: expected %b, got %b",
                     $time, want.is_last, m_tlast);
          end
          if (m_tdata[CHAR_W+COUNT_W-1:CHAR_W] !== want.digit_count) begin
            errors++;
            $display("%0t: digit_count mismatch: expected %0d, got %0d",
                     $time, want.digit_count, m_tdata[CHAR_W+COUNT_W-1:CHAR_W]);
          end
        end
      end
      // Watchdog: cycles without any beat on either side.
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    // Directed part. Zero in two bases gives the single '0'.
    add_number(64'd0, 6'd10);
    add_number(64'd0, 6'd2);
    // Widest results: all ones in base two gives the full 64 digits.
    add_number({VALUE_W{1'b1}}, 6'd2);
    add_number({VALUE_W{1'b1}}, 6'd10);
    add_number({VALUE_W{1'b1}}, 6'd36);
    add_number(64'h8000_0000_0000_0000, 6'd2);
    add_number(64'd1, 6'd2);
    // Digit boundaries: the last numeral, the first letter and 'Z'.
    add_number(64'd9, 6'd10);
    add_number(64'd10, 6'd10);
    add_number(64'd10, 6'd11);
    add_number(64'd35, 6'd36);
    add_number(64'd36, 6'd36);
    add_number(64'hFEDC_BA98_7654_3210, 6'd16);
    add_number(64'd1295, 6'd36);
    // Bases below two act as two.
    add_number(64'd5, 6'd0);
    add_number(64'hAAAA, 6'd1);
    // Bases above thirty-six act as thirty-six, up to the all-ones field; legal bases are mixed in.
    add_number(64'd1295, 6'd37);
    add_number(64'h0123_4567_89AB_CDEF, 6'd63);
    add_number(64'd71, 6'd35);
    add_number(64'd1, 6'd63);
    add_number(64'h5555_5555_5555_5555, 6'd3);
    add_number(64'd123456789, 6'd10);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_number(rand_value(), rand_radix());
    end
    n_items = number_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every number taken and every digit seen, then a quiet spell in which
    // any stray beat would still be caught.
    wait (in_accepted == n_items && expected_digits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_digits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
